/* rtl/bdeq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared types, field widths and codes for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  // Field widths of the request and response beats.
  localparam int unsigned OpcodeW = 3;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 7;

  typedef logic [OpcodeW-1:0]       opcode_t;
  typedef logic signed [WordW-1:0]  word_t;
  typedef logic [PosW-1:0]          pos_t;

  // Opcodes as they arrive on the request channel.
  localparam opcode_t OP_INS_FRONT = 3'd0;
  localparam opcode_t OP_INS_BACK  = 3'd1;
  localparam opcode_t OP_DEL_FRONT = 3'd2;
  localparam opcode_t OP_DEL_BACK  = 3'd3;
  localparam opcode_t OP_SEARCH    = 3'd4;
  localparam opcode_t OP_DISPLAY   = 3'd5;

  // Response status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Decoded command kinds passed from the front end to the back end.
  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_SEARCH    = 3'd4,
    CMD_DISPLAY   = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    word_t     value;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/bdeq_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------

// Request channel: one operation per beat.
interface bdeq_req_if;
  import bdeq_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  word_t   value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Response channel: one result per beat.
interface bdeq_rsp_if;
  import bdeq_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  word_t              data;
  pos_t               position;
  logic               last;

  modport source (output valid, output status, output data, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input last, output ready);
endinterface
`default_nettype wire

/* rtl/bdeq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bdeq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the output holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/bdeq_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque front end
// Accepts request beats, decodes the opcode and forwards valid commands.
// ----------------------------------------------------------------------------
module bdeq_front (
  bdeq_req_if.sink           req_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output bdeq_pkg::cmd_t     cmd_o
);
  import bdeq_pkg::*;

  logic op_ok;

  // Decode the opcode; unused opcodes are taken and dropped.
  always_comb begin
    op_ok       = 1'b1;
    cmd_o.kind  = CMD_INS_FRONT;
    cmd_o.value = req_i.value;
    unique case (req_i.opcode)
      OP_INS_FRONT: cmd_o.kind = CMD_INS_FRONT;
      OP_INS_BACK:  cmd_o.kind = CMD_INS_BACK;
      OP_DEL_FRONT: cmd_o.kind = CMD_DEL_FRONT;
      OP_DEL_BACK:  cmd_o.kind = CMD_DEL_BACK;
      OP_SEARCH:    cmd_o.kind = CMD_SEARCH;
      OP_DISPLAY:   cmd_o.kind = CMD_DISPLAY;
      default:      op_ok      = 1'b0;
    endcase
  end

  assign cmd_valid_o = req_i.valid && op_ok;
  assign req_i.ready = !op_ok || cmd_ready_i;

endmodule
`default_nettype wire

/* rtl/bdeq_cmdq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bdeq_cmdq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  bdeq_pkg::cmd_t       push_cmd_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_i,
  output bdeq_pkg::cmd_t       pop_cmd_o
);
  import bdeq_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/bdeq_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque back end
// Holds the ring state and entry RAM, executes commands and drives results.
// ----------------------------------------------------------------------------
module bdeq_back #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  input  bdeq_pkg::cmd_t     cmd_i,
  bdeq_rsp_if.source         rsp_o
);
  import bdeq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] idx_q, idx_d;
  word_t           key_q, key_d;
  logic            disp_q, disp_d;

  logic            out_valid_q;
  status_e         status_q;
  word_t           data_q;
  pos_t            position_q;
  logic            last_q;

  logic            load;
  status_e         ld_status;
  word_t           ld_data;
  pos_t            ld_position;
  logic            ld_last;

  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;
  word_t           rdata;
  logic            out_free, full, empty, at_last;
  logic [IdxW-1:0] front_dec, front_inc, slot_fill;
  logic [IdxW-1:0] idx_next;

  // Ring slot that lies off places behind base, with one wrap correction.
  function automatic logic [IdxW-1:0] ring_slot(input logic [IdxW-1:0] base,
                                                input logic [SumW-1:0] off);
    logic [SumW-1:0] s;
    s = {1'b0, base} + off;
    if (s >= SumW'(DEPTH)) begin
      s = s - SumW'(DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  bdeq_ram #(
    .WIDTH (WordW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Occupancy flags and neighbor indexes.
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign full      = (fill_q == CntW'(DEPTH));
  assign empty     = (fill_q == '0);
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign slot_fill = ring_slot(front_q, SumW'(fill_q));
  assign idx_next  = idx_q + 1'b1;
  assign at_last   = ((SumW'(idx_q) + 1'b1) == SumW'(fill_q));

  // Command execution and the entry walk for search and display.
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    key_d       = key_q;
    disp_d      = disp_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = slot_fill;
    re          = 1'b0;
    raddr       = ring_slot(front_q, SumW'(idx_next));
    load        = 1'b0;
    ld_status   = ST_OK;
    ld_data     = '0;
    ld_position = '0;
    ld_last     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          load      = 1'b1;
          unique case (cmd_i.kind)
            CMD_INS_FRONT: begin
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                front_d = front_dec;
                we      = 1'b1;
                waddr   = front_dec;
                fill_d  = fill_q + 1'b1;
              end
            end
            CMD_INS_BACK: begin
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                we     = 1'b1;
                fill_d = fill_q + 1'b1;
              end
            end
            CMD_DEL_FRONT: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                front_d = front_inc;
                fill_d  = fill_q - 1'b1;
              end
            end
            CMD_DEL_BACK: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                fill_d = fill_q - 1'b1;
              end
            end
            CMD_SEARCH, CMD_DISPLAY: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                // Start the walk at the front entry; results come later.
                load    = 1'b0;
                re      = 1'b1;
                raddr   = front_q;
                idx_d   = '0;
                key_d   = cmd_i.value;
                disp_d  = (cmd_i.kind == CMD_DISPLAY);
                state_d = S_WALK;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end

      S_WALK: begin
        // The read data belongs to entry idx_q; it holds while stalled.
        if (out_free) begin
          if (disp_q) begin
            load    = 1'b1;
            ld_data = rdata;
            ld_last = at_last;
            if (at_last) begin
              state_d = S_IDLE;
            end else begin
              re    = 1'b1;
              idx_d = idx_next;
            end
          end else if (rdata == key_q) begin
            load        = 1'b1;
            ld_position = PosW'(idx_q) + 1'b1;
            state_d     = S_IDLE;
          end else if (at_last) begin
            load      = 1'b1;
            ld_status = ST_MISS;
            state_d   = S_IDLE;
          end else begin
            re    = 1'b1;
            idx_d = idx_next;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      fill_q  <= fill_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk context and the response payload.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    disp_q <= disp_d;
    if (load) begin
      status_q   <= ld_status;
      data_q     <= ld_data;
      position_q <= ld_position;
      last_q     <= ld_last;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.data     = data_q;
  assign rsp_o.position = position_q;
  assign rsp_o.last     = last_q;

endmodule
`default_nettype wire

/* rtl/bounded_deque_with_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque with search
// Double-ended queue of signed 32-bit words with search and display.
// ----------------------------------------------------------------------------
// Each request beat carries one operation; a front end decodes it and drops
// opcodes 6 and 7 without a response, and a two-entry command queue feeds the
// back end, which holds the ring state and a DEPTH-word entry RAM. Inserts and
// deletes give one response beat each. Search reads one entry per cycle while
// the response channel does not stall, through the single RAM read port, up
// to the first hit (position counted from 1 at the front) or a miss. Display
// gives one beat per stored entry, front to back, one per cycle while not
// stalled, with last set on the final beat. Deletes, search or display on an
// empty store, or inserts into a full one, give one beat with matching status.
// Back-pressure on the response channel stalls the back end in place; the
// request channel keeps taking beats until the command queue fills.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bdeq_req_if.sink    req_i,
  bdeq_rsp_if.source  rsp_o
);
  import bdeq_pkg::*;

  logic fe_valid, fe_ready;
  cmd_t fe_cmd;
  logic be_valid, be_pop;
  cmd_t be_cmd;

  bdeq_front u_front (
    .req_i       (req_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  bdeq_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_cmd_i   (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_i        (be_pop),
    .pop_cmd_o    (be_cmd)
  );

  bdeq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_pop_o   (be_pop),
    .cmd_i       (be_cmd),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire
